/* rtl/core/spad_pkg.sv */
// spad_pkg: shared types, constants and the advance table of the spark
// advance and dwell scheduler; no dependencies
package spad_pkg;

  localparam int SPEED_BINS = 16;
  localparam int LOAD_BINS  = 12;
  localparam int CYLINDERS  = 2;

  // shared divider and multiplier widths
  localparam int DIV_DW = 32;
  localparam int DIV_VW = 20;
  localparam int MUL_AW = 20;
  localparam int MUL_BW = 18;

  // configuration register indexes
  localparam logic [1:0] REG_MIN_ADV = 2'd0;
  localparam logic [1:0] REG_MAX_ADV = 2'd1;
  localparam logic [1:0] REG_DWELL   = 2'd2;

  // alarm request codes
  localparam logic [1:0] REQ_NONE   = 2'd0;
  localparam logic [1:0] REQ_SET    = 2'd1;
  localparam logic [1:0] REQ_CANCEL = 2'd2;

  // pending action codes
  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_CHARGE = 2'd1;
  localparam logic [1:0] ACT_FIRE   = 2'd2;

  localparam logic [13:0] MIN_RPM     = 14'd200;
  localparam logic [5:0]  DWELL_CAP   = 6'd60;
  localparam logic [31:0] ALARM_MAX   = 32'd200000;
  localparam logic [31:0] US_PER_DEG3 = 32'd500000;
  // six times the us-rpm product at or above this gives more than 60 degrees
  localparam logic [31:0] DWELL_SAT   = 32'd61000000;
  // ceil(2^31 / 15625): x / 1e6 taken as ((x >> 6) * RECIP_US) >> 31
  localparam logic [17:0] RECIP_US    = 18'd137439;
  localparam logic [17:0] RECIP10     = 18'd52429;
  localparam logic [9:0]  CYCLE_DEG   = 10'd720;
  localparam logic [2:0]  NEAR_DEG    = 3'd5;

  localparam logic signed [11:0] TDC_DEG [2] = '{12'sd0, 12'sd360};

  localparam logic [13:0] SPEED_AXIS [SPEED_BINS] = '{
    14'd800, 14'd1000, 14'd1200, 14'd1500, 14'd1800, 14'd2200, 14'd2600, 14'd3000,
    14'd3500, 14'd4000, 14'd4500, 14'd5000, 14'd5500, 14'd6000, 14'd6500, 14'd7000};

  localparam logic [8:0] LOAD_AXIS [LOAD_BINS] = '{
    9'd0, 9'd50, 9'd100, 9'd150, 9'd200, 9'd250, 9'd300, 9'd350, 9'd400, 9'd450,
    9'd480, 9'd500};

  localparam logic [5:0] ADV_ROM [SPEED_BINS][LOAD_BINS] = '{
    '{6'd8,  6'd8,  6'd7,  6'd7,  6'd6,  6'd6,  6'd5,  6'd5,  6'd5,  6'd4,  6'd4,  6'd4},
    '{6'd10, 6'd10, 6'd9,  6'd9,  6'd8,  6'd8,  6'd7,  6'd7,  6'd6,  6'd6,  6'd5,  6'd5},
    '{6'd12, 6'd12, 6'd11, 6'd11, 6'd10, 6'd10, 6'd9,  6'd9,  6'd8,  6'd7,  6'd6,  6'd6},
    '{6'd15, 6'd14, 6'd13, 6'd12, 6'd12, 6'd11, 6'd10, 6'd10, 6'd9,  6'd8,  6'd7,  6'd7},
    '{6'd18, 6'd17, 6'd16, 6'd15, 6'd14, 6'd13, 6'd12, 6'd11, 6'd10, 6'd9,  6'd8,  6'd8},
    '{6'd22, 6'd21, 6'd20, 6'd18, 6'd17, 6'd16, 6'd15, 6'd14, 6'd13, 6'd12, 6'd10, 6'd10},
    '{6'd25, 6'd24, 6'd23, 6'd21, 6'd20, 6'd18, 6'd17, 6'd16, 6'd15, 6'd13, 6'd12, 6'd11},
    '{6'd28, 6'd27, 6'd25, 6'd23, 6'd22, 6'd20, 6'd19, 6'd17, 6'd16, 6'd14, 6'd13, 6'd12},
    '{6'd30, 6'd29, 6'd27, 6'd25, 6'd23, 6'd22, 6'd20, 6'd19, 6'd17, 6'd16, 6'd14, 6'd13},
    '{6'd32, 6'd30, 6'd28, 6'd26, 6'd24, 6'd23, 6'd21, 6'd20, 6'd18, 6'd17, 6'd15, 6'd14},
    '{6'd33, 6'd31, 6'd29, 6'd27, 6'd25, 6'd24, 6'd22, 6'd21, 6'd19, 6'd17, 6'd16, 6'd15},
    '{6'd34, 6'd32, 6'd30, 6'd28, 6'd26, 6'd25, 6'd23, 6'd22, 6'd20, 6'd18, 6'd17, 6'd16},
    '{6'd34, 6'd32, 6'd30, 6'd28, 6'd26, 6'd25, 6'd23, 6'd22, 6'd20, 6'd18, 6'd17, 6'd16},
    '{6'd33, 6'd31, 6'd29, 6'd27, 6'd25, 6'd24, 6'd22, 6'd21, 6'd19, 6'd18, 6'd16, 6'd15},
    '{6'd32, 6'd30, 6'd28, 6'd26, 6'd24, 6'd23, 6'd21, 6'd20, 6'd18, 6'd17, 6'd15, 6'd14},
    '{6'd30, 6'd28, 6'd26, 6'd24, 6'd22, 6'd21, 6'd19, 6'd18, 6'd17, 6'd16, 6'd14, 6'd13}};

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [5:0] adv_at(logic [3:0] r, logic [3:0] m);
    return ADV_ROM[r][m];
  endfunction

endpackage

/* rtl/core/spad_mul.sv */
// spad_mul: shared unsigned multiplier with registered product
// depends on spad_pkg for operand widths
module spad_mul #(
  parameter int AW = spad_pkg::MUL_AW,
  parameter int BW = spad_pkg::MUL_BW
) (
  input  logic          clk,
  input  logic [AW-1:0] a,
  input  logic [BW-1:0] b,
  output logic [AW+BW-1:0] p
);
  import spad_pkg::*;

  always_ff @(posedge clk) begin
    p <= (AW+BW)'(a) * (AW+BW)'(b);
  end

endmodule

/* rtl/core/spad_div.sv */
// spad_div: shared restoring divider, one quotient bit per cycle
// depends on spad_pkg for widths and the status struct
module spad_div #(
  parameter int DW = spad_pkg::DIV_DW,
  parameter int VW = spad_pkg::DIV_VW
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [DW-1:0]       dividend,
  input  logic [VW-1:0]       divisor,
  output logic [DW-1:0]       quotient,
  output spad_pkg::div_stat_t stat
);
  import spad_pkg::*;

  localparam int CW = $clog2(DW);

  logic [CW-1:0] cnt;
  logic [VW-1:0] rem;
  logic [VW-1:0] dv;
  logic [VW:0]   sh;
  logic [VW:0]   diff;
  logic          qbit;
  logic [VW-1:0] rem_next;

  assign sh       = {rem, quotient[DW-1]};
  assign diff     = sh - {1'b0, dv};
  assign qbit     = (sh >= {1'b0, dv});
  assign rem_next = qbit ? diff[VW-1:0] : sh[VW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= '0;
      end else if (stat.busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DW - 1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
      dv       <= divisor;
    end else if (stat.busy) begin
      rem      <= rem_next;
      quotient <= {quotient[DW-2:0], qbit};
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> $past(stat.busy))
    else $error("divider done without a running division");

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    start |-> !stat.busy)
    else $error("divider started while busy");

  a_end_gives_done: assert property (@(posedge clk) disable iff (rst)
    $fell(stat.busy) |-> stat.done)
    else $error("division ended without done");

  a_busy_not_done: assert property (@(posedge clk) disable iff (rst)
    stat.busy |-> !stat.done)
    else $error("divider busy and done together");

endmodule

/* rtl/core/spark_advance_dwell_scheduler.sv */
// spark_advance_dwell_scheduler: top level, sequencer around one shared
// multiplier (spad_mul) and one shared divider (spad_div); uses spad_pkg
//
// One item at a time. An alarm expiry or a kill (no sync, or speed below 200
// rpm) goes from setup straight to the output state. A control tick runs 13
// multiplier steps for the table interpolation, dwell product, dwell angle
// by reciprocal and crank scaling, one division for the advance and a scan
// of the request slots, plus one more division for every charge or fire
// request that the tick raises; at most one per cylinder. The 32-step
// divider takes the largest share of the time. The result sits in an output
// register, so the next item is taken while it waits.
module spark_advance_dwell_scheduler (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // engine_speed, load_pressure, crank_tenths, synced
  input  logic        s_tuser,   // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // coil_drive, advance_q8, alarm_request, alarm_delay_us,
                                 // alarm_action, alarm_cylinder
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data
);
  import spad_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE      = 7'b000_0001,
    ST_SETUP     = 7'b000_0010,
    ST_MUL       = 7'b000_0100,
    ST_DIV_ADV   = 7'b000_1000,
    ST_PLAN      = 7'b001_0000,
    ST_ALARM     = 7'b010_0000,
    ST_OUT       = 7'b100_0000
  } state_t;

  state_t state;

  // configuration
  logic signed [6:0] min_adv;
  logic signed [6:0] max_adv;
  logic [14:0]       dwell_time_us;

  // block state
  logic [1:0]         armed;
  logic [1:0]         charging;
  logic [1:0]         pact;
  logic               pcyl;
  logic signed [14:0] cadv;

  // latched item
  logic               cmd_r;
  logic [13:0]        rpm_r;
  logic signed [11:0] load_r;
  logic [12:0]        tenths_r;
  logic               sync_r;

  // interpolation cell
  logic [3:0] ri, mi, ri_c, mi_c;
  logic [8:0] dr, wr, dr_c, wr_c;
  logic [5:0] dm, wm, dm_c, wm_c;
  logic [8:0] lc;
  logic [13:0] lo_s;
  logic [8:0]  lo_m;

  // work registers
  logic [3:0]  step;
  logic [14:0] t00, t10, t01, t11;
  logic [19:0] acc;
  logic [14:0] den;
  logic [29:0] dwp;
  logic [31:0] dwx;
  logic [9:0]  cur;
  logic [9:0]  q10;
  logic [5:0]  dwell;
  logic [3:0]  rq;
  logic [2:0]  nsel [4];
  logic [1:0]  ai;
  logic        dstarted;
  logic [1:0]  req_o;
  logic [17:0] delay_o;

  // shared units
  logic [MUL_AW-1:0]        mul_a;
  logic [MUL_BW-1:0]        mul_b;
  logic [MUL_AW+MUL_BW-1:0] p;
  logic                     div_start;
  logic [DIV_DW-1:0]        div_n;
  logic [DIV_VW-1:0]        div_d;
  logic [DIV_DW-1:0]        quo;
  div_stat_t                dstat;

  // plan lanes
  logic signed [15:0] adj;
  logic signed [11:0] advd;
  logic signed [11:0] fire_a [2];
  logic signed [11:0] chg_a  [2];
  logic signed [11:0] dc_a   [2];
  logic signed [11:0] df_a   [2];
  logic [3:0]         rq_c;
  logic [1:0]         arm_c;

  logic signed [15:0] qs, mn, mx, clamp_lo, clamp_hi;
  logic [15:0]        rpm3;
  logic               alarm_ok;

  assign s_tready = (state == ST_IDLE);

  // table cell search over the constant axes
  always_comb begin
    if (load_r < 0) lc = 9'd0;
    else if (load_r > 12'sd500) lc = 9'd500;
    else lc = load_r[8:0];
    ri_c = '0;
    for (int i = 0; i < SPEED_BINS - 1; i++) begin
      if (rpm_r >= SPEED_AXIS[i]) ri_c = 4'(i);
    end
    mi_c = '0;
    for (int i = 0; i < LOAD_BINS - 1; i++) begin
      if (lc >= LOAD_AXIS[i]) mi_c = 4'(i);
    end
    lo_s = SPEED_AXIS[ri_c];
    lo_m = LOAD_AXIS[mi_c];
    dr_c = 9'(SPEED_AXIS[4'(ri_c + 4'd1)] - lo_s);
    dm_c = 6'(LOAD_AXIS[4'(mi_c + 4'd1)] - lo_m);
    if (rpm_r < lo_s) wr_c = '0;
    else if ((rpm_r - lo_s) > 14'(dr_c)) wr_c = dr_c;
    else wr_c = 9'(rpm_r - lo_s);
    if (lc < lo_m) wm_c = '0;
    else if ((lc - lo_m) > 9'(dm_c)) wm_c = dm_c;
    else wm_c = 6'(lc - lo_m);
  end

  // six times the us-rpm product
  assign dwx = {dwp, 2'b00} + {1'b0, dwp, 1'b0};

  // multiplier operand schedule
  always_comb begin
    unique case (step)
      4'd0: begin mul_a = 20'(dr - wr); mul_b = 18'(dm - wm); end
      4'd1: begin mul_a = 20'(wr);      mul_b = 18'(dm - wm); end
      4'd2: begin mul_a = 20'(dr - wr); mul_b = 18'(wm);      end
      4'd3: begin mul_a = 20'(wr);      mul_b = 18'(wm);      end
      4'd4: begin mul_a = 20'(t00); mul_b = 18'(adv_at(ri, mi)); end
      4'd5: begin mul_a = 20'(t10); mul_b = 18'(adv_at(4'(ri + 4'd1), mi)); end
      4'd6: begin mul_a = 20'(t01); mul_b = 18'(adv_at(ri, 4'(mi + 4'd1))); end
      4'd7: begin
        mul_a = 20'(t11);
        mul_b = 18'(adv_at(4'(ri + 4'd1), 4'(mi + 4'd1)));
      end
      4'd8:  begin mul_a = 20'(dr);            mul_b = 18'(dm);    end
      4'd9:  begin mul_a = 20'(dwell_time_us); mul_b = 18'(rpm_r); end
      4'd10: begin mul_a = 20'(tenths_r);      mul_b = RECIP10;    end
      // only meaningful below the saturation point, where x >> 6 fits 20 bits
      4'd11: begin mul_a = dwx[25:6];          mul_b = RECIP_US;   end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  spad_mul #(.AW(MUL_AW), .BW(MUL_BW)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (p)
  );

  assign q10  = p[28:19];
  assign rpm3 = {1'b0, rpm_r, 1'b0} + {2'b00, rpm_r};

  // divider operand select
  always_comb begin
    unique case (state)
      ST_DIV_ADV: begin
        div_n = 32'({acc, 8'h00}) + 32'(den >> 1);
        div_d = 20'(den);
      end
      default: begin
        div_n = 32'(nsel[ai]) * US_PER_DEG3;
        div_d = 20'(rpm3);
      end
    endcase
    div_start = !dstarted &&
                ((state == ST_DIV_ADV) || ((state == ST_ALARM) && rq[ai]));
  end

  spad_div #(.DW(DIV_DW), .VW(DIV_VW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .quotient (quo),
    .stat     (dstat)
  );

  // advance clamp, upper bound wins when the window is inverted
  always_comb begin
    qs       = {2'b00, quo[13:0]};
    mn       = {min_adv[6], min_adv, 8'h00};
    mx       = {max_adv[6], max_adv, 8'h00};
    clamp_lo = (qs < mn) ? mn : qs;
    clamp_hi = (clamp_lo > mx) ? mx : clamp_lo;
  end

  assign alarm_ok = (quo != '0) && (quo <= ALARM_MAX);

  // per-cylinder angle lanes
  always_comb begin
    adj  = {cadv[14], cadv} + (cadv[14] ? 16'sd255 : 16'sd0);
    advd = 12'(adj >>> 8);
    rq_c  = '0;
    arm_c = armed;
    for (int c = 0; c < 2; c++) begin
      fire_a[c] = TDC_DEG[c] - advd;
      if (fire_a[c] < 0) fire_a[c] = fire_a[c] + 12'sd720;
      chg_a[c] = fire_a[c] - $signed({6'b0, dwell});
      if (chg_a[c] < 0) chg_a[c] = chg_a[c] + 12'sd720;
      dc_a[c] = chg_a[c] - $signed({2'b0, cur});
      if (dc_a[c] < 0) dc_a[c] = dc_a[c] + 12'sd720;
      df_a[c] = fire_a[c] - $signed({2'b0, cur});
      if (df_a[c] < 0) df_a[c] = df_a[c] + 12'sd720;
      if (c < CYLINDERS) begin
        if ((dc_a[c] <= $signed({9'b0, NEAR_DEG})) && !armed[c] && !charging[c]) begin
          rq_c[2*c] = 1'b1;
          arm_c[c]  = 1'b1;
        end
        if (charging[c] && (df_a[c] <= $signed({9'b0, NEAR_DEG}))) rq_c[2*c+1] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_tvalid      <= 1'b0;
      min_adv       <= 7'sd0;
      max_adv       <= 7'sd40;
      dwell_time_us <= 15'd3000;
      armed         <= '0;
      charging      <= '0;
      pact          <= ACT_NONE;
      pcyl          <= 1'b0;
      cadv          <= 15'sd2560;
      step          <= '0;
      dstarted      <= 1'b0;
      ai            <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MIN_ADV: min_adv       <= cfg_data[6:0];
          REG_MAX_ADV: max_adv       <= cfg_data[6:0];
          REG_DWELL:   dwell_time_us <= cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (div_start) dstarted <= 1'b1;

      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            cmd_r    <= s_tuser;
            rpm_r    <= s_tdata[13:0];
            load_r   <= s_tdata[25:14];
            tenths_r <= s_tdata[38:26];
            sync_r   <= s_tdata[39];
            state    <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          req_o   <= REQ_NONE;
          delay_o <= '0;
          if (cmd_r) begin
            pact <= ACT_NONE;
            if ((CYLINDERS > 1) || (pcyl == 1'b0)) begin
              if (pact == ACT_CHARGE) begin
                charging[pcyl] <= 1'b1;
              end else if (pact == ACT_FIRE) begin
                charging[pcyl] <= 1'b0;
                armed[pcyl]    <= 1'b0;
              end
            end
            state <= ST_OUT;
          end else if (!sync_r || (rpm_r < MIN_RPM)) begin
            pact     <= ACT_NONE;
            armed    <= '0;
            charging <= '0;
            req_o    <= REQ_CANCEL;
            state    <= ST_OUT;
          end else begin
            ri    <= ri_c;
            mi    <= mi_c;
            dr    <= dr_c;
            dm    <= dm_c;
            wr    <= wr_c;
            wm    <= wm_c;
            step  <= '0;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          step <= step + 4'd1;
          unique case (step)
            4'd1: t00 <= p[14:0];
            4'd2: t10 <= p[14:0];
            4'd3: t01 <= p[14:0];
            4'd4: t11 <= p[14:0];
            4'd5: acc <= p[19:0];
            4'd6, 4'd7, 4'd8: acc <= acc + p[19:0];
            4'd9: den <= p[14:0];
            4'd10: dwp <= p[29:0];
            4'd11: cur <= (q10 >= CYCLE_DEG) ? q10 - CYCLE_DEG : q10;
            4'd12: begin
              dwell    <= (dwx >= DWELL_SAT) ? DWELL_CAP : p[36:31];
              dstarted <= 1'b0;
              state    <= ST_DIV_ADV;
            end
            default: ;
          endcase
        end
        ST_DIV_ADV: begin
          if (dstarted && dstat.done) begin
            cadv     <= clamp_hi[14:0];
            dstarted <= 1'b0;
            state    <= ST_PLAN;
          end
        end
        ST_PLAN: begin
          rq    <= rq_c;
          armed <= arm_c;
          for (int c = 0; c < 2; c++) begin
            nsel[2*c]   <= dc_a[c][2:0];
            nsel[2*c+1] <= df_a[c][2:0];
          end
          ai    <= '0;
          state <= ST_ALARM;
        end
        ST_ALARM: begin
          // requests in cylinder order, charge before fire; last accepted wins
          if (!rq[ai]) begin
            ai <= ai + 2'd1;
            if (ai == 2'd3) state <= ST_OUT;
          end else if (dstarted && dstat.done) begin
            if (alarm_ok) begin
              pact    <= ai[0] ? ACT_FIRE : ACT_CHARGE;
              pcyl    <= ai[1];
              req_o   <= REQ_SET;
              delay_o <= quo[17:0];
            end
            dstarted <= 1'b0;
            ai       <= ai + 2'd1;
            if (ai == 2'd3) state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {pcyl, pact, delay_o, req_o, cadv, charging};
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
